FILE: design/vrlp_pkg.sv
`default_nettype none
package vrlp_pkg;

	localparam int ANGLE_STEPS = 360;
	localparam int QTR_STEPS = 90;
	localparam int TRIG_BITS = 14;
	localparam int ANG_RECIP = 11651;
	localparam int ANG_RECIP_SHIFT = 22;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint ONE_Q30 = 64'sd1073741824;

	localparam int MAG_W = 40;
	localparam int QUO_BITS = 34;
	localparam int DIV_STEP = 2;
	localparam int DIV_STAGES = QUO_BITS / DIV_STEP;

	typedef logic signed [15:0] trig_t;
	typedef trig_t qtr_tab_t [0:QTR_STEPS];

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef enum logic [2:0] {
		CFG_CAM_X  = 3'd0,
		CFG_CAM_Y  = 3'd1,
		CFG_CAM_Z  = 3'd2,
		CFG_HALF_W = 3'd3,
		CFG_HALF_H = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic        vis;
		logic [30:0] depth;
		logic [7:0]  light;
		logic        last;
		logic        neg_x;
		logic        neg_y;
	} side_t;

	// quarter-wave sine, Q1.14, integer Taylor series in Q30
	function automatic qtr_tab_t build_qtr();
		qtr_tab_t t;
		longint x;
		longint x2;
		longint term;
		longint sum;
		for (int k = 0; k <= QTR_STEPS; k++) begin
			x = (longint'(k) * PI_Q30 + 64'sd90) / 64'sd180;
			x2 = x * x / ONE_Q30;
			term = x;
			sum = x;
			for (int n = 1; n <= 7; n++) begin
				term = term * x2 / ONE_Q30;
				unique case (n)
					1: term = -term / 64'sd6;
					2: term = -term / 64'sd20;
					3: term = -term / 64'sd42;
					4: term = -term / 64'sd72;
					5: term = -term / 64'sd110;
					6: term = -term / 64'sd156;
					default: term = -term / 64'sd210;
				endcase
				sum = sum + term;
			end
			if (sum < 0)
				sum = 0;
			t[k] = 16'((sum + 64'sd32768) / 64'sd65536);
		end
		return t;
	endfunction

	localparam qtr_tab_t SIN_QTR = build_qtr();

	function automatic logic signed [31:0] rnd_sat(input logic signed [48:0] v);
		logic signed [48:0] t;
		logic signed [34:0] h;
		t = v + 49'sd8192;
		h = $signed(t[48:TRIG_BITS]);
		if (h > 35'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (h < -35'sd2147483648)
			return 32'sh80000000;
		else
			return h[31:0];
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31])
			return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		else
			return s[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: design/vrlp_div.sv
`default_nettype none
module vrlp_div import vrlp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [FRAC_BITS+12:0]    rem_in,
	input  wire logic [QUO_BITS-1:0]      lo_in,
	input  wire logic [FRAC_BITS+11:0]    den_in,
	output logic      [QUO_BITS-1:0]      quo
);

	localparam int DW = FRAC_BITS + 12;
	localparam int RW = DW + 1;

	logic [RW-1:0]       rem_s [1:DIV_STAGES];
	logic [QUO_BITS-1:0] lo_s  [1:DIV_STAGES];
	logic [QUO_BITS-1:0] quo_s [1:DIV_STAGES];
	logic [DW-1:0]       den_s [1:DIV_STAGES];

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
		logic [RW-1:0]       r_in;
		logic [QUO_BITS-1:0] l_in;
		logic [QUO_BITS-1:0] q_in;
		logic [DW-1:0]       d_in;
		logic [RW-1:0]       r_nx;
		logic [QUO_BITS-1:0] l_nx;
		logic [QUO_BITS-1:0] q_nx;
		logic [RW-1:0]       t;

		if (k == 1) begin : g_first
			assign r_in = rem_in;
			assign l_in = lo_in;
			assign q_in = '0;
			assign d_in = den_in;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign l_in = lo_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
		end

		always_comb begin
			r_nx = r_in;
			l_nx = l_in;
			q_nx = q_in;
			t = '0;
			for (int b = 0; b < DIV_STEP; b++) begin
				t = {r_nx[RW-2:0], l_nx[QUO_BITS-1]};
				l_nx = l_nx << 1;
				if (t >= {1'b0, d_in}) begin
					r_nx = t - {1'b0, d_in};
					q_nx = {q_nx[QUO_BITS-2:0], 1'b1};
				end else begin
					r_nx = t;
					q_nx = {q_nx[QUO_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_nx;
				lo_s[k] <= l_nx;
				quo_s[k] <= q_nx;
				den_s[k] <= d_in;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule
`default_nettype wire

FILE: design/vertex_rotate_light_project_unit.sv
// channel | dir | handshake           | beat
// in      | in  | in_valid/in_stall   | pos_x, pos_y, pos_z, angle, last_vertex
// out     | out | out_valid/out_stall | screen_x, screen_y, depth, light, visible, last_out
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat per cycle in, one per cycle out while out is not stalled; a beat goes through
// the 11 rotate/light/project stages, 17 two-bit divider stages and the output stage.
// Reset clears valid bits and loads the register defaults; cfg_ready is always high.
// A stall on out freezes every stage and stalls in until the output is taken.
`default_nettype none
module vertex_rotate_light_project_unit import vrlp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic [15:0]        angle,
	input  wire logic               last_vertex,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      screen_x,
	output logic signed [31:0]      screen_y,
	output logic [30:0]             depth,
	output logic [7:0]              light,
	output logic                    visible,
	output logic                    last_out,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int DW = FRAC_BITS + 12;
	localparam int RW = DW + 1;
	localparam longint ONE = 64'sd1 <<< FRAC_BITS;
	localparam longint ONE400 = 64'sd400 * ONE;
	localparam longint NEAR_LIM = -64'sd451 * ONE;
	localparam longint FAR_LIM = -64'sd3500 * ONE;
	localparam longint CAM_Z_RST_L = -64'sd1000 * ONE;
	localparam logic signed [31:0] CAM_Z_RST = (CAM_Z_RST_L < -64'sd2147483648) ?
		32'sh80000000 : CAM_Z_RST_L[31:0];

	logic adv;

	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [10:0]        half_w_q, half_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= CAM_Z_RST;
			half_w_q <= 11'd160;
			half_h_q <= 11'd120;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CAM_X:  cam_x_q <= cfg_data;
				CFG_CAM_Y:  cam_y_q <= cfg_data;
				CFG_CAM_Z:  cam_z_q <= cfg_data;
				CFG_HALF_W: half_w_q <= cfg_data[10:0];
				CFG_HALF_H: half_h_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// valid chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11;
	logic vld_d_s [1:DIV_STAGES];
	logic out_vld_q;

	assign adv = !out_vld_q || !out_stall;
	assign in_stall = !adv;
	assign out_valid = out_vld_q;

	// stage 1: angle mod 360
	logic [29:0] ang_mul;
	logic [17:0] ang_rem;
	logic [8:0]  ang_red;
	logic [8:0]  ang_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic last_s1;

	always_comb begin
		ang_mul = 30'(angle) * 30'(ANG_RECIP);
		ang_rem = {2'b00, angle} - 18'(ang_mul[29:ANG_RECIP_SHIFT]) * 18'(ANGLE_STEPS);
		if (ang_rem[17])
			ang_red = 9'(ang_rem + 18'(ANGLE_STEPS));
		else
			ang_red = ang_rem[8:0];
	end

	// stage 2: quadrant
	quad_t       quad_s2;
	logic [6:0]  rr_s2;
	logic signed [31:0] x_s2, y_s2, z_s2;
	logic last_s2;
	quad_t       quad_nx;
	logic [8:0]  rr_nx;

	always_comb begin
		priority if (ang_s1 >= 9'd270) begin
			quad_nx = QUAD_3;
			rr_nx = ang_s1 - 9'd270;
		end else if (ang_s1 >= 9'd180) begin
			quad_nx = QUAD_2;
			rr_nx = ang_s1 - 9'd180;
		end else if (ang_s1 >= 9'd90) begin
			quad_nx = QUAD_1;
			rr_nx = ang_s1 - 9'd90;
		end else begin
			quad_nx = QUAD_0;
			rr_nx = ang_s1;
		end
	end

	// stage 3: sine/cosine lookup
	trig_t sin_s3, cos_s3;
	logic signed [31:0] x_s3, y_s3, z_s3;
	logic last_s3;
	trig_t sa, sb, sin_nx, cos_nx;

	always_comb begin
		sa = SIN_QTR[rr_s2];
		sb = SIN_QTR[7'(QTR_STEPS) - rr_s2];
		unique case (quad_s2)
			QUAD_0: begin sin_nx = sa;  cos_nx = sb;  end
			QUAD_1: begin sin_nx = sb;  cos_nx = -sa; end
			QUAD_2: begin sin_nx = -sa; cos_nx = -sb; end
			QUAD_3: begin sin_nx = -sb; cos_nx = sa;  end
			default: begin sin_nx = sa; cos_nx = sb; end
		endcase
	end

	// stages 4..9: rotations and lighting
	logic signed [47:0] p_a_s4, p_b_s4, p_c_s4, p_d_s4;
	logic signed [31:0] x_s4;
	logic signed [31:0] x_s5, y1_s5, z1_s5;
	logic signed [47:0] p_a_s6, p_b_s6, p_c_s6, p_d_s6;
	logic signed [31:0] y1_s6;
	logic signed [31:0] x1_s7, y1_s7, z2_s7;
	logic signed [47:0] p_a_s8, p_b_s8, p_c_s8, p_d_s8;
	logic signed [31:0] z2_s8;
	logic signed [31:0] x2_s9, y2_s9, z2_s9;
	trig_t sin_s4, cos_s4, sin_s5, cos_s5, sin_s6, cos_s6, sin_s7, cos_s7;
	logic last_s4, last_s5, last_s6, last_s7, last_s8, last_s9;
	logic [7:0] light_s8, light_s9, light_s10, light_nx;

	logic signed [31:0] zip;
	logic signed [32:0] zi;
	logic [9:0]         lmul;

	always_comb begin
		zip = z2_s7 >>> FRAC_BITS;
		if (z2_s7[31] && (|z2_s7[FRAC_BITS-1:0]))
			zip = zip + 32'sd1;
		zi = 33'(zip) + 33'sd50;
		lmul = (10'(zi[6:0]) * 10'd5) >> 1;
		priority if (zi < 0)
			light_nx = 8'd16;
		else if (zi >= 33'sd100)
			light_nx = 8'd255;
		else if (lmul < 10'd16)
			light_nx = 8'd16;
		else
			light_nx = lmul[7:0];
	end

	// stage 10: camera offset
	logic signed [31:0] xc_s10, yc_s10, zc_s10;
	logic last_s10;

	// stage 11: window, depth and divider setup
	side_t               side_s11;
	logic [RW-1:0]       rem_x_s11, rem_y_s11;
	logic [QUO_BITS-1:0] lo_x_s11, lo_y_s11;
	logic [DW-1:0]       den_s11;

	logic signed [40:0] nx, ny;
	logic [MAG_W-1:0]   ax, ay;
	logic [MAG_W+FRAC_BITS-1:0] dvd_x, dvd_y;
	logic signed [63:0] z64, dm;
	logic signed [34:0] dn;
	side_t              side_nx;

	always_comb begin
		z64 = 64'(zc_s10);
		nx = 41'(xc_s10) * 41'sd400;
		ny = 41'(yc_s10) * 41'sd400;
		ax = nx[40] ? MAG_W'(-nx) : MAG_W'(nx);
		ay = ny[40] ? MAG_W'(-ny) : MAG_W'(ny);
		dvd_x = {ax, {FRAC_BITS{1'b0}}};
		dvd_y = {ay, {FRAC_BITS{1'b0}}};
		dm = -z64 - ONE400;
		dn = -(35'(zc_s10) <<< 2);
		side_nx.vis = (z64 <= NEAR_LIM) && (z64 > FAR_LIM);
		if (!side_nx.vis || dn < 0)
			side_nx.depth = '0;
		else if (dn > 35'sd2147483647)
			side_nx.depth = 31'h7FFFFFFF;
		else
			side_nx.depth = dn[30:0];
		side_nx.light = light_s10;
		side_nx.last = last_s10;
		side_nx.neg_x = !nx[40] && (|nx);
		side_nx.neg_y = !ny[40] && (|ny);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1 <= ang_red;
			x_s1 <= pos_x;
			y_s1 <= pos_y;
			z_s1 <= pos_z;
			last_s1 <= last_vertex;

			quad_s2 <= quad_nx;
			rr_s2 <= rr_nx[6:0];
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
			last_s2 <= last_s1;

			sin_s3 <= sin_nx;
			cos_s3 <= cos_nx;
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			z_s3 <= z_s2;
			last_s3 <= last_s2;

			p_a_s4 <= y_s3 * cos_s3;
			p_b_s4 <= z_s3 * sin_s3;
			p_c_s4 <= y_s3 * sin_s3;
			p_d_s4 <= z_s3 * cos_s3;
			x_s4 <= x_s3;
			sin_s4 <= sin_s3;
			cos_s4 <= cos_s3;
			last_s4 <= last_s3;

			y1_s5 <= rnd_sat(49'(p_a_s4) - 49'(p_b_s4));
			z1_s5 <= rnd_sat(49'(p_c_s4) + 49'(p_d_s4));
			x_s5 <= x_s4;
			sin_s5 <= sin_s4;
			cos_s5 <= cos_s4;
			last_s5 <= last_s4;

			p_a_s6 <= x_s5 * cos_s5;
			p_b_s6 <= z1_s5 * sin_s5;
			p_c_s6 <= x_s5 * sin_s5;
			p_d_s6 <= z1_s5 * cos_s5;
			y1_s6 <= y1_s5;
			sin_s6 <= sin_s5;
			cos_s6 <= cos_s5;
			last_s6 <= last_s5;

			x1_s7 <= rnd_sat(49'(p_a_s6) - 49'(p_b_s6));
			z2_s7 <= rnd_sat(49'(p_c_s6) + 49'(p_d_s6));
			y1_s7 <= y1_s6;
			sin_s7 <= sin_s6;
			cos_s7 <= cos_s6;
			last_s7 <= last_s6;

			p_a_s8 <= x1_s7 * cos_s7;
			p_b_s8 <= y1_s7 * sin_s7;
			p_c_s8 <= x1_s7 * sin_s7;
			p_d_s8 <= y1_s7 * cos_s7;
			z2_s8 <= z2_s7;
			light_s8 <= light_nx;
			last_s8 <= last_s7;

			x2_s9 <= rnd_sat(49'(p_a_s8) - 49'(p_b_s8));
			y2_s9 <= rnd_sat(49'(p_c_s8) + 49'(p_d_s8));
			z2_s9 <= z2_s8;
			light_s9 <= light_s8;
			last_s9 <= last_s8;

			xc_s10 <= add_sat(x2_s9, cam_x_q);
			yc_s10 <= add_sat(y2_s9, cam_y_q);
			zc_s10 <= add_sat(z2_s9, cam_z_q);
			light_s10 <= light_s9;
			last_s10 <= last_s9;

			side_s11 <= side_nx;
			rem_x_s11 <= RW'(dvd_x >> QUO_BITS);
			rem_y_s11 <= RW'(dvd_y >> QUO_BITS);
			lo_x_s11 <= dvd_x[QUO_BITS-1:0];
			lo_y_s11 <= dvd_y[QUO_BITS-1:0];
			den_s11 <= dm[DW-1:0];
		end
	end

	// divider stages
	logic [QUO_BITS-1:0] quo_x, quo_y;
	side_t side_d_s [1:DIV_STAGES];

	vrlp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk    (clk),
		.en     (adv),
		.rem_in (rem_x_s11),
		.lo_in  (lo_x_s11),
		.den_in (den_s11),
		.quo    (quo_x)
	);

	vrlp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk    (clk),
		.en     (adv),
		.rem_in (rem_y_s11),
		.lo_in  (lo_y_s11),
		.den_in (den_s11),
		.quo    (quo_y)
	);

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_side
		side_t side_in;
		logic  vld_in;
		if (k == 1) begin : g_first
			assign side_in = side_s11;
			assign vld_in = vld_s11;
		end else begin : g_next
			assign side_in = side_d_s[k-1];
			assign vld_in = vld_d_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv)
				side_d_s[k] <= side_in;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_d_s[k] <= 1'b0;
			else if (adv)
				vld_d_s[k] <= vld_in;
		end
	end

	// output stage
	function automatic logic signed [31:0] finish(input logic [QUO_BITS-1:0] q,
			input logic neg, input logic [10:0] half);
		logic signed [QUO_BITS:0] qs;
		logic signed [63:0]       sum;
		qs = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (qs > 64'sd2147483647)
			qs = (QUO_BITS+1)'(64'sd2147483647);
		else if (qs < -64'sd2147483648)
			qs = (QUO_BITS+1)'(-64'sd2147483648);
		sum = 64'(qs) + (64'(half) <<< FRAC_BITS);
		if (sum > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (sum < -64'sd2147483648)
			return 32'sh80000000;
		else
			return sum[31:0];
	endfunction

	side_t side_end;
	assign side_end = side_d_s[DIV_STAGES];

	always_ff @(posedge clk) begin
		if (adv) begin
			screen_x <= side_end.vis ? finish(quo_x, side_end.neg_x, half_w_q) : '0;
			screen_y <= side_end.vis ? finish(quo_y, side_end.neg_y, half_h_q) : '0;
			depth <= side_end.depth;
			light <= side_end.light;
			visible <= side_end.vis;
			last_out <= side_end.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			out_vld_q <= vld_d_s[DIV_STAGES];
		end
	end

endmodule
`default_nettype wire

FILE: tb/vertex_rotate_light_project_unit_tb.sv
`default_nettype none
module vertex_rotate_light_project_unit_tb;
	import vrlp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CFG_SPARE_LO = 3'd5;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam longint ONE = 64'sd65536;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic [15:0]        ang;
		logic               last;
	} vertex_t;

	typedef struct {
		logic signed [31:0] sx, sy;
		logic [30:0]        dep;
		logic [7:0]         lum;
		logic               vis;
		logic               last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [15:0] angle = '0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] screen_x, screen_y;
	logic [30:0] depth;
	logic [7:0] light;
	logic visible, last_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	vertex_t pending_verts[$];
	pixel_t expected_pixels[$];
	longint sin_tab[0:359];
	longint cos_tab[0:359];
	longint cam_x_m, cam_y_m, cam_z_m, half_w_m, half_h_m;
	int errors = 0;
	bit quiet = 0;
	int hold_reqs = 0, hold_seen = 0, hold_left = 0;

	vertex_rotate_light_project_unit i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint quarter_sin(int k);
		longint x, x2, term, sum;
		x = (longint'(k) * 64'sd3373259426 + 64'sd90) / 64'sd180;
		x2 = x * x / 64'sd1073741824;
		term = x;
		sum = x;
		for (int n = 1; n <= 7; n++) begin
			term = term * x2 / 64'sd1073741824;
			term = -term / longint'((2 * n) * (2 * n + 1));
			sum += term;
		end
		if (sum < 0)
			sum = 0;
		return (sum + 64'sd32768) / 64'sd65536;
	endfunction

	function automatic longint deg_sin(int d);
		case (d / 90)
			0: return quarter_sin(d % 90);
			1: return quarter_sin(90 - d % 90);
			2: return -quarter_sin(d % 90);
			default: return -quarter_sin(90 - d % 90);
		endcase
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint turn(longint a, longint b, longint c, longint s, bit plus);
		longint p;
		p = plus ? a * c + b * s : a * c - b * s;
		return clip32((p + 64'sd8192) >>> 14);
	endfunction

	function automatic longint proj_div(longint n, longint d);
		longint q1, r;
		q1 = n / d;
		r = n % d;
		if (q1 > (64'sd1 <<< 40) || q1 < -(64'sd1 <<< 40))
			return q1 > 0 ? 64'sd2147483647 : -64'sd2147483648;
		return clip32(q1 * ONE + (r * ONE) / d);
	endfunction

	function automatic pixel_t project_vertex(vertex_t v);
		pixel_t r;
		longint x, y, z, s, c, y1, z1, x1, z2, x2, y2, zi, zc, den, dp;
		int a;
		x = v.px;
		y = v.py;
		z = v.pz;
		a = int'(v.ang) % 360;
		s = sin_tab[a];
		c = cos_tab[a];
		y1 = turn(y, z, c, s, 0);
		z1 = turn(y, z, s, c, 1);
		x1 = turn(x, z1, c, s, 0);
		z2 = turn(x, z1, s, c, 1);
		x2 = turn(x1, y1, c, s, 0);
		y2 = turn(x1, y1, s, c, 1);
		zi = z2 / ONE + 50;
		if (zi < 0)
			r.lum = 8'd16;
		else if (zi >= 100)
			r.lum = 8'd255;
		else if (zi * 5 / 2 < 16)
			r.lum = 8'd16;
		else
			r.lum = 8'(zi * 5 / 2);
		x2 = clip32(x2 + cam_x_m);
		y2 = clip32(y2 + cam_y_m);
		z2 = clip32(z2 + cam_z_m);
		zc = z2 / ONE;
		r.vis = (zc < -450) && (zc > -3500);
		r.sx = '0;
		r.sy = '0;
		r.dep = '0;
		if (r.vis) begin
			den = z2 + 400 * ONE;
			r.sx = 32'(clip32(proj_div(x2 * 400, den) + half_w_m * ONE));
			r.sy = 32'(clip32(proj_div(y2 * 400, den) + half_h_m * ONE));
			dp = -4 * z2;
			if (dp > 64'sd2147483647)
				dp = 64'sd2147483647;
			if (dp < 0)
				dp = 0;
			r.dep = 31'(dp);
		end
		r.last = v.last;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vertex_t nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_pixels.push_back(project_vertex('{pos_x, pos_y, pos_z, angle, last_vertex}));
			if (!in_valid || !in_stall) begin
				if (pending_verts.size() > 0 && (quiet || $urandom_range(99) >= 29)) begin
					nv = pending_verts.pop_front();
					pos_x <= nv.px;
					pos_y <= nv.py;
					pos_z <= nv.pz;
					angle <= nv.ang;
					last_vertex <= nv.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		pixel_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected output beat");
					errors++;
				end else begin
					e = expected_pixels.pop_front();
					if (screen_x !== e.sx) begin
						$error("screen_x: expected %0d, got %0d", e.sx, screen_x);
						errors++;
					end
					if (screen_y !== e.sy) begin
						$error("screen_y: expected %0d, got %0d", e.sy, screen_y);
						errors++;
					end
					if (depth !== e.dep) begin
						$error("depth: expected %0d, got %0d", e.dep, depth);
						errors++;
					end
					if (light !== e.lum) begin
						$error("light: expected %0d, got %0d", e.lum, light);
						errors++;
					end
					if (visible !== e.vis) begin
						$error("visible: expected %0b, got %0b", e.vis, visible);
						errors++;
					end
					if (last_out !== e.last) begin
						$error("last_out: expected %0b, got %0b", e.last, last_out);
						errors++;
					end
				end
			end
			if (hold_seen != hold_reqs) begin
				hold_seen <= hold_reqs;
				hold_left <= 300;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 29);
			end
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CAM_X: cam_x_m = longint'($signed(val));
			CFG_CAM_Y: cam_y_m = longint'($signed(val));
			CFG_CAM_Z: cam_z_m = longint'($signed(val));
			CFG_HALF_W: half_w_m = longint'(val[10:0]);
			CFG_HALF_H: half_h_m = longint'(val[10:0]);
			default: ;
		endcase
	endtask

	task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] hw, logic [31:0] hh);
		cfg_write(CFG_CAM_X, cx);
		cfg_write(CFG_CAM_Y, cy);
		cfg_write(CFG_CAM_Z, cz);
		cfg_write(CFG_HALF_W, hw);
		cfg_write(CFG_HALF_H, hh);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_verts.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] near_coord();
		return 32'($signed($urandom_range(600)) - 300) * 32'sd65536 + 32'($urandom_range(65535));
	endfunction

	task automatic push_random(int n);
		vertex_t v;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 70) begin
				v.px = near_coord();
				v.py = near_coord();
				v.pz = near_coord();
				v.ang = $urandom_range(99) < 80 ? 16'($urandom_range(359)) : 16'($urandom);
			end else begin
				v.px = $urandom;
				v.py = $urandom;
				v.pz = $urandom;
				v.ang = 16'($urandom);
			end
			v.last = ($urandom_range(15) == 0);
			pending_verts.push_back(v);
		end
	endtask

	initial begin
		for (int d = 0; d < 360; d++) begin
			sin_tab[d] = deg_sin(d);
			cos_tab[d] = deg_sin((d + 90) % 360);
		end
		cam_x_m = 0;
		cam_y_m = 0;
		cam_z_m = -64'sd65536000;
		half_w_m = 160;
		half_h_m = 120;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_verts.push_back('{32'sd0, 32'sd0, 32'sd0, 16'd0, 1'b0});
		pending_verts.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'd0, 1'b1});
		pending_verts.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'd45, 1'b0});
		pending_verts.push_back('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 16'd359, 1'b0});
		pending_verts.push_back('{32'sd6553600, -32'sd6553600, 32'sd0, 16'd90, 1'b0});
		pending_verts.push_back('{32'sd6553600, 32'sd3276800, 32'sd0, 16'd180, 1'b0});
		pending_verts.push_back('{-32'sd6553600, 32'sd3276800, 32'sd0, 16'd270, 1'b0});
		pending_verts.push_back('{32'sd100, 32'sd200, 32'sd300, 16'd360, 1'b0});
		pending_verts.push_back('{32'sd100, 32'sd200, 32'sd300, 16'hFFFF, 1'b1});
		pending_verts.push_back('{32'sd0, 32'sd0, -32'sd3276800, 16'd0, 1'b0});
		pending_verts.push_back('{32'sd0, 32'sd0, 32'sd3276800, 16'd0, 1'b0});
		pending_verts.push_back('{32'sd0, 32'sd0, 32'sd3276799, 16'd0, 1'b0});
		pending_verts.push_back('{32'sd0, 32'sd0, -32'sd3276801, 16'd0, 1'b0});
		pending_verts.push_back('{32'sd0, 32'sd0, 32'sd35389440, 16'd0, 1'b0});
		pending_verts.push_back('{32'sd0, 32'sd0, -32'sd163840000, 16'd0, 1'b0});
		pending_verts.push_back('{32'sd0, 32'sd0, -32'sd163905536, 16'd0, 1'b0});
		pending_verts.push_back('{32'sd100000000, -32'sd90000000, 32'sd0, 16'd720, 1'b0});
		drain();

		set_camera(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'd2047, 32'd0);
		push_random(20);
		drain();

		set_camera(32'h80000000, 32'h7FFFFFFF, 32'hFD000000, 32'd0, 32'hFFFFFFFF);
		for (logic [3:0] k = 4'(CFG_SPARE_LO); k <= 4'(CFG_SPARE_HI); k++)
			cfg_write(k[2:0], $urandom);
		cfg_valid <= 1'b0;
		@(posedge clk);
		push_random(20);
		drain();

		set_camera(32'd0, 32'd0, 32'hFC180000, 32'd160, 32'd120);
		hold_reqs = hold_reqs + 1;
		push_random(100);
		drain();

		set_camera(32'($signed($urandom_range(200)) - 100) <<< 16,
			32'($signed($urandom_range(200)) - 100) <<< 16,
			32'($signed($urandom_range(2000)) - 2500) <<< 16,
			$urandom_range(2047), $urandom_range(2047));
		quiet = 1;
		push_random(100);
		drain();
		quiet = 0;

		set_camera(32'd0, 32'd0, 32'hFC180000, $urandom, $urandom);
		push_random(160);
		drain();

		if (errors == 0)
			$display("vertex_rotate_light_project_unit_tb: done, clean");
		else
			$display("vertex_rotate_light_project_unit_tb: done, errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("vertex_rotate_light_project_unit_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
design/vrlp_pkg.sv
design/vrlp_div.sv
design/vertex_rotate_light_project_unit.sv
tb/vertex_rotate_light_project_unit_tb.sv
